[rtl/core/mid_pkg.sv]
// Shared types and constants for the memory-image record decoder.
// No dependencies; imported by every module of the block.
package mid_pkg;

    localparam int ADDR_BYTES_DEF = 8;
    localparam int LEN_BYTES_DEF  = 8;

    localparam int ADDR_W   = 64;
    localparam int ADD_W    = 13;
    localparam int LANE_W   = 3;
    localparam int CNT_W    = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam logic [7:0] IDENT [4] = '{8'hFF, 8'h4D, 8'h45, 8'h4D};

    localparam logic [7:0] REC_ABS  = 8'h60;
    localparam logic [7:0] REC_LEN2 = 8'hC0;
    localparam logic [7:0] REC_LENW = 8'hE0;
    localparam logic [7:0] MASK6    = 8'h3F;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_RECORD,
        PH_INC_HIGH,
        PH_OPERAND,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE       = 2'd0,
        KIND_NOT_MEMFILE = 2'd1,
        KIND_INVALID     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_CLEAR,
        OP_LANE,
        OP_WRITE,
        OP_NOTMEM,
        OP_INVALID
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADD_W-1:0]  val;
        logic [LANE_W-1:0] lane;
    } t_cmd;

endpackage

[rtl/core/mid_front.sv]
// Front end: accepts file bytes, tracks header/record parsing and payload counts,
// and issues address/write commands. Depends on mid_pkg.
module mid_front import mid_pkg::*; #(
    parameter int ADDR_BYTES = ADDR_BYTES_DEF,
    parameter int LEN_BYTES  = LEN_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int LenW = LEN_BYTES * 8;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_hpos, n_hpos;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [LANE_W-1:0]  r_lane, n_lane;
    logic               r_target, n_target;
    logic [LenW-1:0]    r_pay, n_pay;
    logic [4:0]         r_low, n_low;
    logic               r_halt, n_halt;

    t_phase             c_phase;
    logic [1:0]         c_hpos;
    logic [CNT_W-1:0]   c_left;
    logic [LANE_W-1:0]  c_lane;
    logic               c_target;
    logic [LenW-1:0]    c_pay;
    logic [4:0]         c_low;
    logic               c_halt;
    logic [7:0]         b;
    t_cmd               cmd;

    assign b = i_data_byte;

    always_comb begin
        c_phase  = r_phase;
        c_hpos   = r_hpos;
        c_left   = r_left;
        c_lane   = r_lane;
        c_target = r_target;
        c_pay    = r_pay;
        c_low    = r_low;
        c_halt   = r_halt;
        if (i_start_of_file) begin
            c_phase  = PH_HEADER;
            c_hpos   = '0;
            c_left   = '0;
            c_lane   = '0;
            c_target = 1'b0;
            c_pay    = '0;
            c_low    = '0;
            c_halt   = 1'b0;
        end

        n_phase  = c_phase;
        n_hpos   = c_hpos;
        n_left   = c_left;
        n_lane   = c_lane;
        n_target = c_target;
        n_pay    = c_pay;
        n_low    = c_low;
        n_halt   = c_halt;
        cmd.op   = i_start_of_file ? OP_CLEAR : OP_NONE;
        cmd.val  = '0;
        cmd.lane = '0;

        if (!c_halt) begin
            unique case (c_phase)
                PH_HEADER: begin
                    if (b != IDENT[c_hpos]) begin
                        n_halt = 1'b1;
                        cmd.op = OP_NOTMEM;
                    end else if (c_hpos == 2'd3) begin
                        n_hpos  = '0;
                        n_phase = PH_RECORD;
                    end else begin
                        n_hpos = c_hpos + 2'd1;
                    end
                end
                PH_INC_HIGH: begin
                    cmd.op  = OP_ADD;
                    cmd.val = ADD_W'(c_low) + {b, 5'd0};
                    n_phase = PH_RECORD;
                end
                PH_OPERAND: begin
                    if (!c_target) begin
                        cmd.op   = OP_LANE;
                        cmd.val  = ADD_W'(b);
                        cmd.lane = c_lane;
                    end else begin
                        n_pay = c_pay | (LenW'(b) << {c_lane, 3'd0});
                    end
                    n_lane = c_lane + LANE_W'(1);
                    if (c_left != '0) begin
                        n_left = c_left - CNT_W'(1);
                    end
                    if (n_left == '0) begin
                        if (!c_target || n_pay == '0) begin
                            n_phase = PH_RECORD;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    cmd.op  = OP_WRITE;
                    cmd.val = ADD_W'(b);
                    n_pay   = c_pay - LenW'(1);
                    if (c_pay == LenW'(1)) begin
                        n_phase = PH_RECORD;
                    end
                end
                PH_RECORD: begin
                    unique case (b[7:5])
                        3'b000, 3'b001: begin
                            cmd.op  = OP_ADD;
                            cmd.val = ADD_W'(b & MASK6);
                        end
                        3'b010: begin
                            n_low   = b[4:0];
                            n_phase = PH_INC_HIGH;
                        end
                        3'b100, 3'b101: begin
                            n_pay   = LenW'(b & MASK6);
                            n_phase = ((b & MASK6) != 8'd0) ? PH_PAYLOAD : PH_RECORD;
                        end
                        default: begin
                            if (b == REC_ABS) begin
                                cmd.op   = OP_CLEAR;
                                n_target = 1'b0;
                                n_left   = CNT_W'(ADDR_BYTES);
                                n_lane   = '0;
                                n_phase  = PH_OPERAND;
                            end else if (b == REC_LEN2 || b == REC_LENW) begin
                                n_target = 1'b1;
                                n_left   = (b == REC_LEN2) ? CNT_W'(2) : CNT_W'(LEN_BYTES);
                                n_lane   = '0;
                                n_pay    = '0;
                                n_phase  = PH_OPERAND;
                            end else begin
                                n_halt = 1'b1;
                                cmd.op = OP_INVALID;
                            end
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    assign o_push = i_take && (cmd.op != OP_NONE);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hpos   <= '0;
            r_left   <= '0;
            r_lane   <= '0;
            r_target <= 1'b0;
            r_pay    <= '0;
            r_low    <= '0;
            r_halt   <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_hpos   <= n_hpos;
            r_left   <= n_left;
            r_lane   <= n_lane;
            r_target <= n_target;
            r_pay    <= n_pay;
            r_low    <= n_low;
            r_halt   <= n_halt;
        end
    end

endmodule

[rtl/core/mid_cmd_fifo.sv]
// Small command queue between the front end and the back end.
// Depends on mid_pkg for the command type and depth.
module mid_cmd_fifo import mid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_pop_cmd,
    output logic o_empty
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_PTR_W:0]   r_cnt;

    assign o_full    = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_pop_cmd = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_PTR_W'(1);
            end
            r_cnt <= r_cnt + (FIFO_PTR_W+1)'(i_push) - (FIFO_PTR_W+1)'(i_pop);
        end
    end

endmodule

[rtl/core/mid_back.sv]
// Back end: holds the running address, executes queued commands and drives
// the result register. Depends on mid_pkg.
module mid_back import mid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output t_kind             o_kind,
    output logic [ADDR_W-1:0] o_addr,
    output logic [7:0]        o_data
);

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_valid, n_valid;
    t_kind             r_kind, n_kind;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [7:0]        r_data, n_data;
    logic              take;

    assign take      = i_cmd_valid && (!r_valid || !i_stall);
    assign o_cmd_pop = take;

    always_comb begin
        n_addr     = r_addr;
        n_valid    = r_valid && i_stall;
        n_kind     = r_kind;
        n_out_addr = r_out_addr;
        n_data     = r_data;
        if (take) begin
            unique case (i_cmd.op)
                OP_ADD:   n_addr = r_addr + ADDR_W'(i_cmd.val);
                OP_CLEAR: n_addr = '0;
                OP_LANE:  n_addr = r_addr | (ADDR_W'(i_cmd.val[7:0]) << {i_cmd.lane, 3'd0});
                OP_WRITE: begin
                    n_valid    = 1'b1;
                    n_kind     = KIND_WRITE;
                    n_out_addr = r_addr;
                    n_data     = i_cmd.val[7:0];
                    n_addr     = r_addr + ADDR_W'(1);
                end
                OP_NOTMEM, OP_INVALID: begin
                    n_valid    = 1'b1;
                    n_kind     = (i_cmd.op == OP_NOTMEM) ? KIND_NOT_MEMFILE : KIND_INVALID;
                    n_out_addr = '0;
                    n_data     = '0;
                end
                default: begin
                    n_addr = r_addr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_out_addr <= n_out_addr;
        r_data     <= n_data;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_out_addr;
    assign o_data  = r_data;

endmodule

[rtl/core/memory_image_record_decoder.sv]
// Memory-image record decoder top level: front end, command queue, back end.
// Depends on mid_pkg, mid_front, mid_cmd_fifo and mid_back.
//
// Input channel: one file byte per transfer (i_valid, o_stall), with
// i_start_of_file marking the first byte of a new file. Output channel: one
// result per transfer (o_valid, i_stall): a memory write (address, data) for
// each payload byte, or a single not-a-memory-file / invalid-record report,
// after which bytes are dropped until the next start of file.
// Throughput: one byte per cycle while o_stall is low. A result passes through
// the queue write, then the back-end result register, after its byte is taken.
// The front end parses records and sends address/write commands through a
// four-entry queue; the back end keeps the running address and the result
// register. When the receiver stalls, the result holds, the queue fills, and
// o_stall rises once the queue is full.
// Reset clears the parser, the queue, the running address and the output valid;
// bytes taken before any start mark are parsed as a file begun at reset.
module memory_image_record_decoder import mid_pkg::*; #(
    parameter int ADDR_BYTES = ADDR_BYTES_DEF,
    parameter int LEN_BYTES  = LEN_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_file,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_result_kind,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [7:0]        o_write_data
);

    logic  take;
    logic  push;
    t_cmd  push_cmd;
    logic  full;
    logic  empty;
    logic  pop;
    t_cmd  pop_cmd;
    t_kind kind;

    assign o_stall = full;
    assign take    = i_valid && !full;

    mid_front #(
        .ADDR_BYTES (ADDR_BYTES),
        .LEN_BYTES  (LEN_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    mid_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (empty)
    );

    mid_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!empty),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (kind),
        .o_addr      (o_write_address),
        .o_data      (o_write_data)
    );

    assign o_result_kind = kind;

endmodule

[verif/memory_image_record_decoder_tb.sv]
// Self-checking testbench for memory_image_record_decoder: directed and random image files.
// Uses a scoreboard class that predicts each write or error report from the bytes.
// Depends on mid_pkg and the memory_image_record_decoder RTL.
module memory_image_record_decoder_tb import mid_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN2_BYTES = 2;

    typedef struct {
        t_kind       kind;
        logic [63:0] addr;
        logic [7:0]  data;
    } t_mem_result;

    typedef struct {
        logic [7:0] value;
        logic       sof;
    } t_file_byte;

    class image_write_scoreboard;
        t_phase      phase;
        logic [1:0]  hdr_pos;
        logic [63:0] cur_addr;
        logic [3:0]  operand_left;
        int          operand_shift;
        logic        fill_length;
        logic [63:0] payload_left;
        logic [4:0]  low_inc;
        logic        halted;
        t_mem_result expected_writes[$];
        int          mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase = PH_HEADER;
            hdr_pos = '0;
            cur_addr = '0;
            operand_left = '0;
            operand_shift = 0;
            fill_length = 1'b0;
            payload_left = '0;
            low_inc = '0;
            halted = 1'b0;
        endfunction

        function void push_result(t_kind kind, logic [63:0] addr, logic [7:0] data);
            t_mem_result r;
            r.kind = kind;
            r.addr = addr;
            r.data = data;
            expected_writes.push_back(r);
        endfunction

        function void start_operand(logic to_length, int count);
            fill_length = to_length;
            operand_left = count[3:0];
            operand_shift = 0;
            if (to_length) begin
                payload_left = '0;
            end else begin
                cur_addr = '0;
            end
            phase = PH_OPERAND;
        endfunction

        function void decode_record(logic [7:0] b);
            casez (b)
                8'b00??????: cur_addr += {56'd0, b & MASK6};
                8'b010?????: begin
                    low_inc = b[4:0];
                    phase = PH_INC_HIGH;
                end
                8'b10??????: begin
                    payload_left = {56'd0, b & MASK6};
                    phase = (payload_left != 0) ? PH_PAYLOAD : PH_RECORD;
                end
                REC_ABS:  start_operand(1'b0, ADDR_BYTES_DEF);
                REC_LEN2: start_operand(1'b1, LEN2_BYTES);
                REC_LENW: start_operand(1'b1, LEN_BYTES_DEF);
                default: begin
                    halted = 1'b1;
                    push_result(KIND_INVALID, '0, '0);
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic sof);
            logic [63:0] part;
            if (sof) restart();
            if (halted) return;
            case (phase)
                PH_HEADER: begin
                    if (b != IDENT[hdr_pos]) begin
                        halted = 1'b1;
                        push_result(KIND_NOT_MEMFILE, '0, '0);
                    end else if (hdr_pos == 2'd3) begin
                        hdr_pos = '0;
                        phase = PH_RECORD;
                    end else begin
                        hdr_pos++;
                    end
                end
                PH_INC_HIGH: begin
                    cur_addr += {59'd0, low_inc} + ({56'd0, b} << 5);
                    phase = PH_RECORD;
                end
                PH_OPERAND: begin
                    part = {56'd0, b} << operand_shift;
                    if (fill_length) begin
                        payload_left |= part;
                    end else begin
                        cur_addr |= part;
                    end
                    operand_shift += 8;
                    if (operand_left != 0) operand_left--;
                    if (operand_left == 0) begin
                        phase = (fill_length && payload_left != 0) ? PH_PAYLOAD : PH_RECORD;
                    end
                end
                PH_PAYLOAD: begin
                    push_result(KIND_WRITE, cur_addr, b);
                    cur_addr += 64'd1;
                    payload_left -= 64'd1;
                    if (payload_left == 0) phase = PH_RECORD;
                end
                default: decode_record(b);
            endcase
        endfunction

        function void flag(string what, t_mem_result want, logic [1:0] kind,
                           logic [63:0] addr, logic [7:0] data);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected kind %0d addr %h data %h, got kind %0d addr %h data %h",
                         what, want.kind, want.addr, want.data, kind, addr, data);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [63:0] addr, logic [7:0] data);
            t_mem_result want;
            want.kind = KIND_WRITE;
            want.addr = '0;
            want.data = '0;
            if (expected_writes.size() == 0) begin
                flag("unexpected result", want, kind, addr, data);
                return;
            end
            want = expected_writes.pop_front();
            if (kind !== want.kind || addr !== want.addr || data !== want.data) begin
                flag("result mismatch", want, kind, addr, data);
            end
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_data_byte = '0;
    logic              i_start_of_file = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_result_kind;
    logic [ADDR_W-1:0] o_write_address;
    logic [7:0]        o_write_data;

    image_write_scoreboard sb;
    t_file_byte            file_stream[$];
    int                    stall_mode = 0;
    int                    stall_left = 0;

    memory_image_record_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_result_kind, o_write_address, o_write_data);
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(10, 80);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= 1'($urandom_range(0, 1));
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic sof);
        t_file_byte fb;
        fb.value = b;
        fb.sof = sof;
        file_stream.push_back(fb);
    endtask

    task automatic load_opening_files();
        logic [7:0] opening[$];
        opening = '{8'hFF, 8'h4D, 8'h45, 8'h4D,
                    8'h60, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h82, 8'hA5, 8'h5A, 8'h80, 8'h3F, 8'h5F, 8'hFF,
                    8'hC0, 8'h01, 8'h00, 8'hC3, 8'h61, 8'h00};
        // first file starts without a start mark
        foreach (opening[i]) put_byte(opening[i], 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h4D, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b1);
    endtask

    task automatic add_random_file();
        logic [7:0]  rec[$];
        logic [63:0] len64;
        int          n_rec;
        int          pick;
        int          pos;
        int          cut;
        int          i;
        int          k;
        bit          near_top;
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, 3);
            for (i = 0; i < pos; i++) rec.push_back(IDENT[i]);
            rec.push_back(IDENT[pos] ^ 8'($urandom_range(1, 255)));
            n_rec = $urandom_range(0, 3);
            for (i = 0; i < n_rec; i++) rec.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (i = 0; i < 4; i++) rec.push_back(IDENT[i]);
            n_rec = $urandom_range(1, 12);
            for (i = 0; i < n_rec; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    rec.push_back(8'($urandom_range(0, 63)));
                end else if (pick < 27) begin
                    rec.push_back(8'h40 | 8'($urandom_range(0, 31)));
                    rec.push_back(8'($urandom_range(0, 255)));
                end else if (pick < 37) begin
                    near_top = ($urandom_range(0, 2) == 0);
                    rec.push_back(REC_ABS);
                    for (k = 0; k < ADDR_BYTES_DEF; k++) begin
                        rec.push_back((near_top && k >= 2) ? 8'hFF : 8'($urandom_range(0, 255)));
                    end
                end else if (pick < 91) begin
                    if (pick < 67) begin
                        len64 = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 63))
                                                            : 64'($urandom_range(0, 8));
                        rec.push_back(8'h80 | len64[7:0]);
                    end else if (pick < 79) begin
                        len64 = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 300))
                                                            : 64'($urandom_range(0, 12));
                        rec.push_back(REC_LEN2);
                        for (k = 0; k < LEN2_BYTES; k++) rec.push_back(len64[8*k +: 8]);
                    end else begin
                        len64 = 64'($urandom_range(0, 12));
                        rec.push_back(REC_LENW);
                        for (k = 0; k < LEN_BYTES_DEF; k++) rec.push_back(len64[8*k +: 8]);
                    end
                    for (k = 0; k < int'(len64); k++) rec.push_back(8'($urandom_range(0, 255)));
                end else if (pick < 96) begin
                    case ($urandom_range(0, 2))
                        0:       rec.push_back(8'h61 + 8'($urandom_range(0, 30)));
                        1:       rec.push_back(8'hC1 + 8'($urandom_range(0, 30)));
                        default: rec.push_back(8'hE1 + 8'($urandom_range(0, 30)));
                    endcase
                    rec.push_back(8'($urandom_range(0, 255)));
                    break;
                end
            end
            if ($urandom_range(0, 99) < 12 && rec.size() > 5) begin
                cut = $urandom_range(5, rec.size() - 1);
                while (rec.size() > cut) rec.delete(rec.size() - 1);
            end
        end
        foreach (rec[j]) put_byte(rec[j], j == 0);
    endtask

    task automatic drive_stream();
        int next_idx;
        int burst_left;
        int gap_left;
        bit done;
        next_idx = 0;
        burst_left = $urandom_range(1, 30);
        gap_left = 0;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            if (i_valid && !o_stall) sb.note_byte(i_data_byte, i_start_of_file);
            if (!(i_valid && o_stall)) begin
                if (next_idx == file_stream.size()) begin
                    i_valid <= 1'b0;
                    done = 1'b1;
                end else if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left--;
                end else begin
                    i_valid <= 1'b1;
                    i_data_byte <= file_stream[next_idx].value;
                    i_start_of_file <= file_stream[next_idx].sof;
                    next_idx++;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    endtask

    initial begin
        sb = new();
        load_opening_files();
        while (file_stream.size() < 930) add_random_file();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_stream();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/core/mid_pkg.sv
rtl/core/mid_front.sv
rtl/core/mid_cmd_fifo.sv
rtl/core/mid_back.sv
rtl/core/memory_image_record_decoder.sv
verif/memory_image_record_decoder_tb.sv
